>>> hdl/ilp_pkg.sv
`default_nettype none

package ilp_pkg;

  typedef enum logic [5:0] {
    PH_WS   = 6'b000001,
    PH_SIGN = 6'b000010,
    PH_ZERO = 6'b000100,
    PH_HEX  = 6'b001000,
    PH_DEC  = 6'b010000,
    PH_DROP = 6'b100000
  } phase_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] COUNT_CAP = 8'd255;

  typedef struct packed {
    phase_t      phase;
    logic        negative;
    logic [31:0] accumulator;
    logic        seen_digit;
    logic        overflow_seen;
  } parse_state_t;

  typedef struct packed {
    logic        success;
    logic [31:0] value;
    logic        overflowed;
    logic [7:0]  consumed;
  } parse_result_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase: PH_WS, negative: 1'b0, accumulator: 32'd0,
    seen_digit: 1'b0, overflow_seen: 1'b0
  };

  // Returns the digit value in the low nibble and a valid flag on top.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
        hex_digit = {1'b1, d[3:0]};
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = c - CH_LA + 8'd10;
        hex_digit = {1'b1, d[3:0]};
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = c - CH_UA + 8'd10;
        hex_digit = {1'b1, d[3:0]};
      end else begin
        hex_digit = 5'd0;
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/ilp_in_stage.sv
`default_nettype none

module ilp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] character,
  input  wire logic       is_final,
  input  wire logic       advance,
  output logic            s_valid,
  output logic [7:0]      s_char,
  output logic            s_fin
);

  // The held beat leaves whenever the step stage can move on.
  assign in_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_char <= character;
      s_fin  <= is_final;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ilp_step.sv
`default_nettype none

module ilp_step #(
  parameter int MAX_COUNT = 255,
  parameter int CW = $clog2(MAX_COUNT + 1)
) (
  input  wire ilp_pkg::parse_state_t cur,
  input  wire logic [CW-1:0]         count,
  input  wire logic [7:0]            c,
  input  wire logic                  fin,
  output ilp_pkg::parse_state_t      nxt,
  output logic [CW-1:0]              count_next,
  output logic                       emit,
  output ilp_pkg::parse_result_t     result
);
  import ilp_pkg::*;

  logic        is_digit;
  logic        is_nonzero;
  logic [7:0]  dig_byte;
  logic [35:0] dec_sum;
  logic [4:0]  hex_d;
  logic        fits;
  logic        dropping;
  logic [CW+7:0] cnt_ext;

  assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_nonzero = (c >= CH_ONE) && (c <= CH_NINE);
  assign dig_byte   = c - CH_ZERO;
  // acc * 10 + d as two shifted copies of the accumulator.
  assign dec_sum = {1'b0, cur.accumulator, 3'b000} + {3'b000, cur.accumulator, 1'b0}
                 + {32'd0, dig_byte[3:0]};
  assign hex_d = hex_digit(c);

  always_comb begin
    parse_state_t s;
    s        = cur;
    fits     = 1'b0;
    dropping = 1'b0;
    unique case (cur.phase)
      PH_WS, PH_SIGN: begin
        if (cur.phase == PH_WS && (c == CH_SPACE || c == CH_TAB)) begin
          fits = 1'b1;
        end else if (cur.phase == PH_WS && c == CH_MINUS) begin
          s.negative = 1'b1;
          s.phase    = PH_SIGN;
          fits       = 1'b1;
        end else if (cur.phase == PH_WS && c == CH_PLUS) begin
          s.phase = PH_SIGN;
          fits    = 1'b1;
        end else if (c == CH_ZERO) begin
          s.accumulator = 32'd0;
          s.seen_digit  = 1'b1;
          s.phase       = PH_ZERO;
          fits          = 1'b1;
        end else if (is_nonzero) begin
          s.accumulator   = dec_sum[31:0];
          s.overflow_seen = cur.overflow_seen || (dec_sum[35:32] != 4'd0);
          s.seen_digit    = 1'b1;
          s.phase         = PH_DEC;
          fits            = 1'b1;
        end
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          s.seen_digit  = 1'b0;
          s.accumulator = 32'd0;
          s.phase       = PH_HEX;
          fits          = 1'b1;
        end else if (is_digit) begin
          s.accumulator   = dec_sum[31:0];
          s.overflow_seen = cur.overflow_seen || (dec_sum[35:32] != 4'd0);
          s.seen_digit    = 1'b1;
          s.phase         = PH_DEC;
          fits            = 1'b1;
        end
      end
      PH_HEX: begin
        if (hex_d[4]) begin
          s.overflow_seen = cur.overflow_seen || (cur.accumulator[31:28] != 4'd0);
          s.accumulator   = {cur.accumulator[27:0], hex_d[3:0]};
          s.seen_digit    = 1'b1;
          fits            = 1'b1;
        end
      end
      PH_DEC: begin
        if (is_digit) begin
          s.accumulator   = dec_sum[31:0];
          s.overflow_seen = cur.overflow_seen || (dec_sum[35:32] != 4'd0);
          s.seen_digit    = 1'b1;
          fits            = 1'b1;
        end
      end
      default: begin
        // Drop phase, and any code that should never appear.
        dropping = 1'b1;
      end
    endcase

    count_next = count;
    if (fits && (count < CW'(MAX_COUNT))) begin
      count_next = count + 1'b1;
    end

    // The result reflects the state after this byte when it fits.
    cnt_ext = {8'd0, count_next};
    if (s.seen_digit) begin
      result.success    = 1'b1;
      result.value      = s.negative ? (32'd0 - s.accumulator) : s.accumulator;
      result.overflowed = s.overflow_seen;
      result.consumed   = (cnt_ext > (CW+8)'(COUNT_CAP)) ? COUNT_CAP : cnt_ext[7:0];
    end else begin
      result = '0;
    end

    if (dropping) begin
      emit = 1'b0;
      nxt  = fin ? STATE_CLEAR : cur;
    end else if (fits) begin
      emit = fin;
      nxt  = fin ? STATE_CLEAR : s;
    end else begin
      emit = 1'b1;
      nxt  = s;
      nxt.phase = PH_DROP;
      if (fin) begin
        nxt = STATE_CLEAR;
      end
    end
    // Every final byte closes the string, so the count starts over.
    if (fin) begin
      count_next = '0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/integer_literal_parser_top.sv
`default_nettype none

// Streaming parser for signed decimal or 0x/0X hexadecimal integer literals.
// One character is taken per cycle while the output is not stalled; the beat that
// ends the literal passes the input register, then the string's single result is
// held in the result register. The per-character state update is a shift-add of
// the 32-bit accumulator, computed combinationally.
// Leading spaces and tabs and one sign are accepted; the first unfitting
// byte ends the literal and later bytes are dropped through the final flag.
module integer_literal_parser_top #(
  parameter int MAX_COUNT = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  character,
  input  wire logic        is_final,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             success,
  output logic signed [31:0] value,
  output logic             overflowed,
  output logic [7:0]       consumed
);
  import ilp_pkg::*;

  localparam int CW = $clog2(MAX_COUNT + 1);

  logic          s_valid;
  logic [7:0]    s_char;
  logic          s_fin;
  logic          out_free;
  logic          fire;
  parse_state_t  st;
  parse_state_t  st_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          emit;
  parse_result_t res;

  assign out_free = !out_valid || out_ready;
  assign fire     = s_valid && out_free;

  ilp_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .is_final  (is_final),
    .advance   (out_free),
    .s_valid   (s_valid),
    .s_char    (s_char),
    .s_fin     (s_fin)
  );

  ilp_step #(
    .MAX_COUNT (MAX_COUNT),
    .CW        (CW)
  ) u_step (
    .cur        (st),
    .count      (count),
    .c          (s_char),
    .fin        (s_fin),
    .nxt        (st_next),
    .count_next (count_next),
    .emit       (emit),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= STATE_CLEAR;
      count <= '0;
    end else if (fire) begin
      st    <= st_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      success    <= res.success;
      value      <= res.value;
      overflowed <= res.overflowed;
      consumed   <= res.consumed;
    end
  end

endmodule

`default_nettype wire

>>> tb/integer_literal_parser_top_tb.sv
`timescale 1ns / 100ps

module integer_literal_parser_top_tb;
  import ilp_pkg::*;

  localparam int MAX_COUNT    = 255;
  localparam int IDLE_PCT     = 37;
  localparam int RANDOM_ITEMS = 1450;
  localparam int STALL_LIMIT  = 4000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       hold;
  } char_beat_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic [7:0]        character = 8'd0;
  logic              is_final = 1'b0;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              success;
  logic signed [31:0] value;
  logic              overflowed;
  logic [7:0]        consumed;

  char_beat_t    char_q[$];
  parse_result_t expected_literals[$];
  logic [7:0]    word_buf[$];

  int   queued_items = 0;
  int   beats_sent = 0;
  int   stall_cycles = 0;
  int   faults = 0;
  logic in_fire = 1'b0;
  logic calm;

  // Predicted parser state.
  phase_t      lit_phase = PH_WS;
  logic        lit_negative = 1'b0;
  logic [31:0] lit_acc = 32'd0;
  logic        lit_seen = 1'b0;
  logic        lit_ovf = 1'b0;
  int          lit_count = 0;

  integer_literal_parser_top #(.MAX_COUNT(MAX_COUNT)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .character(character),
    .is_final(is_final),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .success(success),
    .value(value),
    .overflowed(overflowed),
    .consumed(consumed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  task automatic clear_literal();
    lit_phase = PH_WS;
    lit_negative = 1'b0;
    lit_acc = 32'd0;
    lit_seen = 1'b0;
    lit_ovf = 1'b0;
    lit_count = 0;
  endtask

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  task automatic add_decimal(input logic [7:0] d);
    logic [63:0] wide;
    wide = {32'd0, lit_acc} * 64'd10 + {56'd0, d};
    if (wide[63:32] != 32'd0) lit_ovf = 1'b1;
    lit_acc = wide[31:0];
    lit_seen = 1'b1;
  endtask

  task automatic start_number(input logic [7:0] c, output logic fits);
    fits = 1'b1;
    if (c == CH_ZERO) begin
      lit_acc = 32'd0;
      lit_seen = 1'b1;
      lit_phase = PH_ZERO;
    end else if (is_digit(c)) begin
      add_decimal(c - CH_ZERO);
      lit_phase = PH_DEC;
    end else begin
      fits = 1'b0;
    end
  endtask

  function automatic parse_result_t literal_result();
    parse_result_t r;
    r = '0;
    if (lit_seen) begin
      r.success = 1'b1;
      r.value = lit_negative ? (32'd0 - lit_acc) : lit_acc;
      r.overflowed = lit_ovf;
      r.consumed = (lit_count > 255) ? COUNT_CAP : lit_count[7:0];
    end
    return r;
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic fin);
    logic       fits;
    logic [7:0] nib;
    fits = 1'b0;
    nib = 8'd0;
    if (lit_phase == PH_DROP) begin
      if (fin) clear_literal();
    end else begin
      case (lit_phase)
        PH_WS: begin
          if (c == CH_SPACE || c == CH_TAB) begin
            fits = 1'b1;
          end else if (c == CH_MINUS) begin
            lit_negative = 1'b1;
            lit_phase = PH_SIGN;
            fits = 1'b1;
          end else if (c == CH_PLUS) begin
            lit_phase = PH_SIGN;
            fits = 1'b1;
          end else begin
            start_number(c, fits);
          end
        end
        PH_SIGN: start_number(c, fits);
        PH_ZERO: begin
          if (c == CH_LX || c == CH_UX) begin
            // The leading zero of a prefix does not count as a digit.
            lit_seen = 1'b0;
            lit_acc = 32'd0;
            lit_phase = PH_HEX;
            fits = 1'b1;
          end else if (is_digit(c)) begin
            add_decimal(c - CH_ZERO);
            lit_phase = PH_DEC;
            fits = 1'b1;
          end
        end
        PH_HEX: begin
          if (is_digit(c)) begin
            nib = c - CH_ZERO;
            fits = 1'b1;
          end else if (c >= CH_LA && c <= CH_LF) begin
            nib = c - CH_LA + 8'd10;
            fits = 1'b1;
          end else if (c >= CH_UA && c <= CH_UF) begin
            nib = c - CH_UA + 8'd10;
            fits = 1'b1;
          end
          if (fits) begin
            if (lit_acc[31:28] != 4'd0) lit_ovf = 1'b1;
            lit_acc = {lit_acc[27:0], nib[3:0]};
            lit_seen = 1'b1;
          end
        end
        default: begin
          if (is_digit(c)) begin
            add_decimal(c - CH_ZERO);
            fits = 1'b1;
          end
        end
      endcase
      if (fits) begin
        if (lit_count < MAX_COUNT) lit_count++;
        if (fin) begin
          expected_literals.push_back(literal_result());
          clear_literal();
        end
      end else begin
        expected_literals.push_back(literal_result());
        if (fin) clear_literal();
        else lit_phase = PH_DROP;
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
  endtask

  task automatic add_digits(input bit hex, input int count);
    int v;
    repeat (count) begin
      v = hex ? $urandom_range(15) : $urandom_range(9);
      if (v < 10) word_buf.push_back(8'(CH_ZERO + v));
      else if ($urandom_range(1) == 1) word_buf.push_back(8'(CH_LA + v - 10));
      else word_buf.push_back(8'(CH_UA + v - 10));
    end
  endtask

  task automatic add_lead(input int max_ws);
    repeat ($urandom_range(max_ws)) word_buf.push_back(($urandom_range(1) == 1) ? CH_SPACE : CH_TAB);
    case ($urandom_range(2))
      1: word_buf.push_back(CH_MINUS);
      2: word_buf.push_back(CH_PLUS);
      default: ;
    endcase
  endtask

  task automatic flush_word(input bit hold);
    char_beat_t b;
    for (int i = 0; i < word_buf.size(); i++) begin
      b.ch = word_buf[i];
      b.fin = (i == word_buf.size() - 1);
      b.hold = hold && (i == 0);
      char_q.push_back(b);
    end
    queued_items += word_buf.size();
    word_buf.delete();
  endtask

  initial begin : stimulus
    int n_strings;
    int kind;
    n_strings = 0;

    queue_text("0x");          flush_word(1'b0);
    queue_text("0");           flush_word(1'b0);
    queue_text("-7");          flush_word(1'b0);
    queue_text("+ 5");         flush_word(1'b0);
    queue_text(" \tz");        flush_word(1'b0);
    queue_text("0XfF;");       flush_word(1'b0);
    queue_text("1a");          flush_word(1'b0);
    queue_text("-0x80000000"); flush_word(1'b0);
    word_buf.push_back(8'h00); flush_word(1'b0);
    word_buf.push_back(8'hFF); flush_word(1'b0);

    while (queued_items < RANDOM_ITEMS + 25) begin
      kind = $urandom_range(99);
      if (n_strings == 10 || n_strings == 30) begin
        // Long whitespace run drives the consumed count near or into saturation.
        repeat ($urandom_range(250, 262)) word_buf.push_back(CH_SPACE);
        add_digits(1'b0, $urandom_range(1, 4));
      end else if (kind < 70) begin
        add_lead(3);
        if ($urandom_range(2) == 0) begin
          word_buf.push_back(CH_ZERO);
          word_buf.push_back(($urandom_range(1) == 1) ? CH_LX : CH_UX);
          add_digits(1'b1, $urandom_range(1, 10));
        end else begin
          add_digits(1'b0, $urandom_range(1, 12));
        end
        if ($urandom_range(1) == 1)
          repeat ($urandom_range(1, 4)) word_buf.push_back(8'($urandom_range(255)));
      end else if (kind < 85) begin
        add_lead(2);
        if ($urandom_range(1) == 1) begin
          word_buf.push_back(CH_ZERO);
          word_buf.push_back(($urandom_range(1) == 1) ? CH_LX : CH_UX);
        end
        repeat ($urandom_range(1, 3))
          word_buf.push_back(($urandom_range(3) == 0) ? CH_SPACE : 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 6)) word_buf.push_back(8'($urandom_range(255)));
      end
      flush_word(n_strings % 60 == 5);
      n_strings++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (char_q.size() != 0 || in_valid || expected_literals.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (faults == 0 && expected_literals.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  assign calm = (beats_sent >= 500) && (beats_sent < 800);

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      // A beat marked hold waits until every pending literal has drained.
      if (char_q.size() != 0 && !(char_q[0].hold && expected_literals.size() != 0) &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        character <= char_q[0].ch;
        is_final <= char_q[0].fin;
        void'(char_q.pop_front());
        beats_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : monitor
    parse_result_t want;
    if (rst) begin
      in_fire = 1'b0;
      stall_cycles = 0;
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) parse_char(character, is_final);
      if (out_valid && out_ready) begin
        if (expected_literals.size() == 0) begin
          if (faults < REPORT_LIMIT)
            $display("unexpected literal: success=%0b value=%0d overflowed=%0b consumed=%0d",
                     success, value, overflowed, consumed);
          faults++;
        end else begin
          want = expected_literals.pop_front();
          if (success !== want.success || value !== want.value ||
              overflowed !== want.overflowed || consumed !== want.consumed) begin
            if (faults < REPORT_LIMIT)
              $display({"literal mismatch: expected %0b/%0d/%0b/%0d, ",
                        "got %0b/%0d/%0b/%0d (success/value/overflowed/consumed)"},
                       want.success, $signed(want.value), want.overflowed, want.consumed,
                       success, value, overflowed, consumed);
            faults++;
          end
        end
      end
      if (in_fire || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

endmodule

>>> integer_literal_parser_top.f
hdl/ilp_pkg.sv
hdl/ilp_in_stage.sv
hdl/ilp_step.sv
hdl/integer_literal_parser_top.sv
tb/integer_literal_parser_top_tb.sv
